FILE: rtl/bcp_pkg.sv
// ----------------------------------------------------------------------------
// Battery current from power: shared package
// Widths, status codes and the side-band records that travel with each beat
// through the pipeline.
// ----------------------------------------------------------------------------
package bcp_pkg;

  // Default number of fraction bits of the fixed-point format.
  localparam int FRAC_BITS_DEF = 16;

  // Quotient bits that each divider produces before saturation.
  localparam int QUO_W = 32;

  // Discriminant numerator, its square root and the derived products.
  localparam int SQ_IN_W = 66;
  localparam int ROOT_W  = 33;
  localparam int DEN_W   = 34;
  localparam int SPLIT_W = 17;
  localparam int PROD_W  = ROOT_W + SPLIT_W;
  localparam int SD_W    = 67;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NEG_DISC  = 2'd1,
    ST_ZERO_DISC = 2'd2,
    ST_ZERO_RES  = 2'd3
  } bcp_status_t;

  // Special-case flags of one beat.
  typedef struct packed {
    logic neg;
    logic rzero;
    logic dneg;
    logic dzero;
  } bcp_flag_t;

  // Operands and flags carried alongside the square root.
  typedef struct packed {
    bcp_flag_t   flag;
    logic [31:0] pmag;
    logic [30:0] v;
    logic [30:0] r;
  } bcp_side_t;

endpackage

FILE: rtl/bcp_div_pipe.sv
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Produces one quotient bit per stage and flags a quotient that does not fit
// in QW bits. A new beat may enter every cycle while en is high.
// ----------------------------------------------------------------------------
module bcp_div_pipe
  import bcp_pkg::*;
#(
  parameter int NW = 48,
  parameter int DW = 32,
  parameter int QW = QUO_W
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo,
  output logic          ovf
);

  localparam int HW = NW - QW;
  localparam int CW = (HW > DW) ? HW : DW;

  logic [DW-1:0] rem [0:QW-1];
  logic [DW-1:0] dd  [0:QW-1];
  logic [QW-1:0] lo  [0:QW];
  logic          of  [0:QW];

  logic [CW-1:0] hi_ext;
  logic [CW-1:0] den_ext;

  // The high part of the numerator must stay below the divisor.
  assign hi_ext  = CW'(num[NW-1:QW]);
  assign den_ext = CW'(den);

  always_ff @(posedge clk) begin
    if (en) begin
      of[0]  <= (hi_ext >= den_ext);
      rem[0] <= hi_ext[DW-1:0];
      lo[0]  <= num[QW-1:0];
      dd[0]  <= den;
    end
  end

  // One quotient bit per stage; quotient bits shift into the low word.
  for (genvar k = 1; k <= QW; k++) begin : g_stage
    logic [DW:0]   t;
    logic          ge;
    logic [DW:0]   diff;

    assign t    = {rem[k-1], lo[k-1][QW-1]};
    assign ge   = (t >= {1'b0, dd[k-1]});
    assign diff = t - {1'b0, dd[k-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        lo[k] <= {lo[k-1][QW-2:0], ge};
        of[k] <= of[k-1];
      end
    end

    if (k < QW) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem[k] <= ge ? diff[DW-1:0] : t[DW-1:0];
          dd[k]  <= dd[k-1];
        end
      end
    end
  end

  assign quo = lo[QW];
  assign ovf = of[QW];

endmodule

FILE: rtl/battery_current_from_power.sv
// ----------------------------------------------------------------------------
// Battery current from power
// Solves p = voc*I - r*I^2 for the smaller root and its voltage gradient.
// ----------------------------------------------------------------------------
// The block takes one beat per cycle while it is not stalled and returns one
// result per beat, in order, through the operand setup registers, the bit-pair
// square root stages, the registers forming V + S and S*(V + S), the three
// parallel one-bit-per-stage dividers and one output register. The whole
// pipeline holds while a finished result is stalled, and in_stall is raised
// only then. Special cases are reported on status: negative discriminant,
// zero discriminant (gradient saturated to the negative limit) and zero
// resistance (both results zero). All results saturate to 32 bits.
// ----------------------------------------------------------------------------
module battery_current_from_power
  import bcp_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] power_w,
  input  logic [30:0]        open_volts,
  input  logic [30:0]        resist_ohm,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] current_a,
  output logic signed [31:0] grad_voc,
  output logic [1:0]         status
);

  localparam int HALF_NW = 31 + FRAC_BITS;
  localparam int Q_NW    = 33 + FRAC_BITS;
  localparam int G_NW    = 33 + 2 * FRAC_BITS;
  localparam int DIV_LAT = QUO_W + 1;

  logic adv;

  // The pipeline moves unless a finished result is held by the receiver.
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Operand setup: magnitude of power, then the two products.
  logic        vld0;
  bcp_side_t   side0;
  logic [31:0] pw;

  assign pw = power_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld0 <= 1'b0;
    end else if (adv) begin
      vld0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side0.flag.neg   <= pw[31];
      side0.flag.rzero <= (resist_ohm == 31'd0);
      side0.flag.dneg  <= 1'b0;
      side0.flag.dzero <= 1'b0;
      side0.pmag       <= pw[31] ? (~pw + 32'd1) : pw;
      side0.v          <= open_volts;
      side0.r          <= resist_ohm;
    end
  end

  logic        vld1;
  bcp_side_t   side1;
  logic [61:0] vsq1;
  logic [62:0] pr1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else if (adv) begin
      vld1 <= vld0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vsq1  <= 62'(side0.v) * 62'(side0.v);
      pr1   <= 63'(side0.pmag) * 63'(side0.r);
      side1 <= side0;
    end
  end

  // Discriminant numerator N = V^2 - 4PR and its sign classification.
  logic [64:0]         pr4;
  logic [64:0]         vsq_e;
  logic [SQ_IN_W-1:0]  n_next;
  bcp_side_t           side2_next;

  assign pr4   = {pr1, 2'b00};
  assign vsq_e = 65'(vsq1);

  always_comb begin
    side2_next = side1;
    side2_next.flag.dneg  = !side1.flag.neg && (pr4 > vsq_e);
    side2_next.flag.dzero = !side1.flag.neg && (pr4 == vsq_e);
    if (side1.flag.neg) begin
      n_next = SQ_IN_W'(vsq_e) + SQ_IN_W'(pr4);
    end else begin
      n_next = SQ_IN_W'(vsq_e) - SQ_IN_W'(pr4);
    end
  end

  // Square root: one result bit per stage over bit pairs of N.
  logic [SQ_IN_W-1:0] sq_bits [0:ROOT_W];
  logic [ROOT_W+1:0]  sq_rem  [0:ROOT_W];
  logic [ROOT_W-1:0]  sq_root [0:ROOT_W];
  bcp_side_t          sq_side [0:ROOT_W];
  logic [ROOT_W:0]    sq_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_vld[0] <= 1'b0;
    end else if (adv) begin
      sq_vld[0] <= vld1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_bits[0] <= n_next;
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
      sq_side[0] <= side2_next;
    end
  end

  for (genvar k = 1; k <= ROOT_W; k++) begin : g_sqrt
    logic [ROOT_W+1:0] t;
    logic [ROOT_W+1:0] trial;
    logic              ge;

    assign t     = {sq_rem[k-1][ROOT_W-1:0], sq_bits[k-1][SQ_IN_W-1 -: 2]};
    assign trial = {sq_root[k-1], 2'b01};
    assign ge    = (t >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_vld[k] <= 1'b0;
      end else if (adv) begin
        sq_vld[k] <= sq_vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_rem[k]  <= ge ? (t - trial) : t;
        sq_root[k] <= {sq_root[k-1][ROOT_W-2:0], ge};
        sq_bits[k] <= {sq_bits[k-1][SQ_IN_W-3:0], 2'b00};
        sq_side[k] <= sq_side[k-1];
      end
    end
  end

  // Denominators: V + S, then S*(V + S) from two half-width products.
  logic              vld_m1, vld_m2, vld_m3;
  bcp_side_t         side_m1, side_m2, side_m3;
  logic [ROOT_W-1:0] s_m1;
  logic [DEN_W-1:0]  den_m1, den_m2, den_m3;
  logic [PROD_W-1:0] pl_m2, ph_m2;
  logic [SD_W-1:0]   sd_m3;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_m1 <= 1'b0;
      vld_m2 <= 1'b0;
      vld_m3 <= 1'b0;
    end else if (adv) begin
      vld_m1 <= sq_vld[ROOT_W];
      vld_m2 <= vld_m1;
      vld_m3 <= vld_m2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s_m1    <= sq_root[ROOT_W];
      den_m1  <= DEN_W'(sq_side[ROOT_W].v) + DEN_W'(sq_root[ROOT_W]);
      side_m1 <= sq_side[ROOT_W];
      pl_m2   <= PROD_W'(s_m1) * PROD_W'(den_m1[SPLIT_W-1:0]);
      ph_m2   <= PROD_W'(s_m1) * PROD_W'(den_m1[DEN_W-1:SPLIT_W]);
      den_m2  <= den_m1;
      side_m2 <= side_m1;
      sd_m3   <= SD_W'(pl_m2) + (SD_W'(ph_m2) << SPLIT_W);
      den_m3  <= den_m2;
      side_m3 <= side_m2;
    end
  end

  // Three dividers in parallel: V/(2R), the current and the gradient.
  logic [QUO_W-1:0] half_q, cur_q, grad_q;
  logic             half_of, cur_of, grad_of;

  bcp_div_pipe #(.NW(HALF_NW), .DW(32), .QW(QUO_W)) u_div_half (
    .clk (clk),
    .en  (adv),
    .num ({side_m3.v, FRAC_BITS'(0)}),
    .den ({side_m3.r, 1'b0}),
    .quo (half_q),
    .ovf (half_of)
  );

  bcp_div_pipe #(.NW(Q_NW), .DW(DEN_W), .QW(QUO_W)) u_div_cur (
    .clk (clk),
    .en  (adv),
    .num ({side_m3.pmag, (FRAC_BITS + 1)'(0)}),
    .den (den_m3),
    .quo (cur_q),
    .ovf (cur_of)
  );

  bcp_div_pipe #(.NW(G_NW), .DW(SD_W), .QW(QUO_W)) u_div_grad (
    .clk (clk),
    .en  (adv),
    .num ({side_m3.pmag, (2 * FRAC_BITS + 1)'(0)}),
    .den (sd_m3),
    .quo (grad_q),
    .ovf (grad_of)
  );

  // Flags and valid bits ride alongside the dividers.
  logic [DIV_LAT-1:0] dv_vld;
  bcp_flag_t          dv_flag [0:DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_vld <= '0;
    end else if (adv) begin
      dv_vld <= {dv_vld[DIV_LAT-2:0], vld_m3};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_flag[0] <= side_m3.flag;
      for (int i = 1; i < DIV_LAT; i++) begin
        dv_flag[i] <= dv_flag[i-1];
      end
    end
  end

  // Saturate a magnitude with its sign to the signed 32-bit range.
  function automatic logic [31:0] sat_mag(input logic [31:0] mag, input logic ovf,
                                          input logic neg);
    logic [31:0] res;
    if (ovf) begin
      res = neg ? 32'h8000_0000 : 32'h7fff_ffff;
    end else if (neg) begin
      res = (mag > 32'h8000_0000) ? 32'h8000_0000 : (~mag + 32'd1);
    end else begin
      res = (mag > 32'h7fff_ffff) ? 32'h7fff_ffff : mag;
    end
    return res;
  endfunction

  // Output register: select by special case and saturate.
  bcp_flag_t   fl;
  logic [31:0] cur_next, grad_next;
  bcp_status_t st_next;

  assign fl = dv_flag[DIV_LAT-1];

  always_comb begin
    if (fl.rzero) begin
      cur_next  = '0;
      grad_next = '0;
      st_next   = ST_ZERO_RES;
    end else if (fl.dneg) begin
      cur_next  = sat_mag(half_q, half_of, 1'b0);
      grad_next = '0;
      st_next   = ST_NEG_DISC;
    end else if (fl.dzero) begin
      cur_next  = sat_mag(half_q, half_of, 1'b0);
      grad_next = 32'h8000_0000;
      st_next   = ST_ZERO_DISC;
    end else begin
      cur_next  = sat_mag(cur_q, cur_of, fl.neg);
      grad_next = sat_mag(grad_q, grad_of, !fl.neg);
      st_next   = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv_vld[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      current_a <= $signed(cur_next);
      grad_voc  <= $signed(grad_next);
      status    <= st_next;
    end
  end

  // A zero resistance clears both results.
  a_zero_res: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_ZERO_RES) |-> (current_a == 0) && (grad_voc == 0))
    else $error("zero resistance result is not cleared");

  // A negative discriminant gives a zero gradient and a nonnegative current.
  a_neg_disc: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_NEG_DISC) |-> (grad_voc == 0) && !current_a[31])
    else $error("negative discriminant result is malformed");

  // A zero discriminant saturates the gradient to the negative limit.
  a_zero_disc: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_ZERO_DISC) |-> (grad_voc == 32'sh8000_0000))
    else $error("zero discriminant gradient is not saturated");

  // A stalled result stays valid until the receiver takes it.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("held result was dropped");

endmodule

FILE: tb/tb_battery_current_from_power.sv
// ----------------------------------------------------------------------------
// Battery current from power: testbench
// Drives power, voltage and resistance beats with random gaps and output
// stalls. A bit-exact predictor of the quadratic solution sits in the
// testbench, and every result beat is checked in order against it.
// ----------------------------------------------------------------------------
module tb_battery_current_from_power
  import bcp_pkg::*;
();

  localparam int FB        = FRAC_BITS_DEF;
  localparam int PIPE_LAT  = 80;
  localparam int MAX_CYCLES = 1000000;

  typedef struct {
    logic [31:0] cur;
    logic [31:0] grad;
    bcp_status_t st;
  } solution_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [31:0] power_w = '0;
  logic [30:0]        open_volts = '0;
  logic [30:0]        resist_ohm = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] current_a;
  logic signed [31:0] grad_voc;
  logic [1:0]         status;

  solution_t pending_q[$];
  int unsigned n_sent = 0;
  int unsigned n_checked = 0;
  int unsigned n_errors = 0;
  int unsigned n_status[4] = '{0, 0, 0, 0};
  int unsigned cycle_cnt = 0;
  bit          quiet_sender = 1'b0;
  bit          quiet_receiver = 1'b0;

  battery_current_from_power u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .power_w   (power_w),
    .open_volts(open_volts),
    .resist_ohm(resist_ohm),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .current_a (current_a),
    .grad_voc  (grad_voc),
    .status    (status)
  );

  // Clock with a period of 8.
  always #4 clk = ~clk;

  // Run limit.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > MAX_CYCLES) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("status: fail");
      $finish;
    end
  end

  // Clamps a magnitude with a sign to the signed 32-bit range.
  function automatic logic [31:0] clamp32(input logic [127:0] mag, input bit neg);
    if (neg) begin
      if (mag > 128'h8000_0000) return 32'h8000_0000;
      return 32'(-mag[31:0]);
    end
    if (mag > 128'h7fff_ffff) return 32'h7fff_ffff;
    return mag[31:0];
  endfunction

  // Floor square root of a discriminant numerator below 2^66.
  function automatic logic [63:0] floor_root(input logic [127:0] n);
    logic [63:0]  root;
    logic [63:0]  t;
    logic [127:0] t2;
    root = '0;
    for (int i = 34; i >= 0; i--) begin
      t  = root | (64'd1 << i);
      t2 = 128'(t) * 128'(t);
      if (t2 <= n) root = t;
    end
    return root;
  endfunction

  // Solves one beat: smaller root, voltage gradient and status.
  function automatic solution_t solve_current(input logic [31:0] p, input logic [30:0] v,
                                              input logic [30:0] r);
    solution_t   res;
    bit          neg;
    logic [63:0] pmag, vsq, pr4, half, s, den, q;
    logic [127:0] n, gq;
    neg  = p[31];
    pmag = neg ? (64'h1_0000_0000 - 64'(p)) : 64'(p);
    if (r == 0) begin
      res.cur = '0; res.grad = '0; res.st = ST_ZERO_RES;
      return res;
    end
    vsq  = 64'(v) * 64'(v);
    pr4  = (pmag * 64'(r)) << 2;
    half = (64'(v) << FB) / (64'(r) << 1);
    if (neg) begin
      n = 128'(vsq) + 128'(pr4);
    end else if (pr4 > vsq) begin
      res.cur = clamp32(128'(half), 1'b0); res.grad = '0; res.st = ST_NEG_DISC;
      return res;
    end else begin
      n = 128'(vsq - pr4);
      if (n == 0) begin
        res.cur = clamp32(128'(half), 1'b0); res.grad = 32'h8000_0000;
        res.st = ST_ZERO_DISC;
        return res;
      end
    end
    s   = floor_root(n);
    den = 64'(v) + s;
    q   = (pmag << (FB + 1)) / den;
    gq  = (128'(pmag) << (2 * FB + 1)) / (128'(s) * 128'(den));
    res.cur  = clamp32(128'(q), neg);
    res.grad = clamp32(gq, !neg);
    res.st   = ST_OK;
    return res;
  endfunction

  // Mostly short gaps, sometimes none for a while, a few long ones.
  function automatic int pick_gap();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    n_errors++;
    $display("mismatch at result %0d: %s got %h expected %h", n_checked, what, got, want);
  endtask

  // Sends one beat and records its predicted solution once accepted.
  task automatic send_beat(input logic [31:0] p, input logic [30:0] v, input logic [30:0] r);
    int gap;
    gap = quiet_sender ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   = 1'b1;
    power_w    = p;
    open_volts = v;
    resist_ohm = r;
    do @(posedge clk); while (in_stall);
    pending_q.push_back(solve_current(p, v, r));
    n_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  // Receiver stall, with quiet stretches and occasional long holds.
  always @(negedge clk) begin
    if (quiet_receiver || rst) begin
      out_stall = 1'b0;
    end else begin
      out_stall = ($urandom_range(0, 99) < 25);
      if ($urandom_range(0, 299) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(10, 40)) @(negedge clk);
      end
    end
  end

  // Result checker.
  always @(posedge clk) begin
    solution_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        n_errors++;
        $display("result beat with nothing expected: %h %h %0d", current_a, grad_voc, status);
      end else begin
        want = pending_q.pop_front();
        if (current_a !== want.cur) report_mismatch("current_a", current_a, want.cur);
        if (grad_voc !== want.grad) report_mismatch("grad_voc", grad_voc, want.grad);
        if (status !== want.st) report_mismatch("status", 32'(status), 32'(want.st));
        n_status[want.st]++;
      end
      n_checked++;
    end
  end

  // Each special case and the field extremes.
  task automatic test_special_cases();
    send_beat(32'h0001_0000, 31'h0005_0000, 31'd0);          // zero resistance
    send_beat(32'h8000_0000, 31'h7fff_ffff, 31'd0);
    send_beat(32'h0010_0000, 31'h0001_0000, 31'h0001_0000);  // negative discriminant
    send_beat(32'h7fff_ffff, 31'd1, 31'h7fff_ffff);
    send_beat(32'd1, 31'd4, 31'd4);                          // zero discriminant
    send_beat(32'd0, 31'd0, 31'h0000_8000);                  // zero voltage, zero power
    send_beat(32'h0004_0000, 31'h0004_0000, 31'h0001_0000);  // exact double root
    send_beat(32'd0, 31'h000c_0000, 31'h0000_4000);          // zero power
    send_beat(32'hfffe_0000, 31'h000c_0000, 31'h0000_4000);  // charging power
    send_beat(32'h8000_0000, 31'h7fff_ffff, 31'h7fff_ffff);
    send_beat(32'h8000_0000, 31'd0, 31'd1);
    send_beat(32'h7fff_ffff, 31'h7fff_ffff, 31'd1);
    send_beat(32'h0000_0001, 31'h7fff_ffff, 31'd1);          // tiny root, gradient rounds to zero
    send_beat(32'hffff_ffff, 31'h7fff_ffff, 31'h7fff_ffff);
    send_beat(32'h0002_0000, 31'h000c_0000, 31'h0000_1999);  // ordinary cell
    send_beat(32'h0000_0000, 31'h7fff_ffff, 31'h7fff_ffff);
    send_beat(32'h0000_0001, 31'd1, 31'd1);                  // negative discriminant
    send_beat(32'hffff_ffff, 31'd0, 31'd1);
  endtask

  // Resistance or voltage drawn over many magnitudes.
  function automatic logic [30:0] spread31();
    logic [30:0] x;
    x = 31'($urandom) >> $urandom_range(0, 30);
    return x;
  endfunction

  // Mostly solvable beats: power chosen within the real-root range.
  task automatic test_random_solvable(input int count);
    logic [30:0] v, r;
    logic [63:0] lim, pm;
    logic [31:0] p;
    for (int i = 0; i < count; i++) begin
      v = spread31();
      r = spread31();
      if (r == 0) r = 31'd1;
      lim = (64'(v) * 64'(v)) / (64'(r) << 2);
      if (lim > 64'h7fff_ffff) lim = 64'h7fff_ffff;
      pm  = {$urandom, $urandom} % (lim + 1);
      case ($urandom_range(0, 9))
        0:       p = 32'(lim);
        1, 2:    p = 32'(-pm);
        3:       p = $urandom;
        default: p = 32'(pm);
      endcase
      send_beat(p, v, r);
    end
  endtask

  // Full-range noise, including zero resistance now and then.
  task automatic test_random_full_range(input int count);
    logic [30:0] r;
    for (int i = 0; i < count; i++) begin
      r = ($urandom_range(0, 19) == 0) ? 31'd0 : 31'($urandom);
      send_beat($urandom, 31'($urandom), r);
    end
  endtask

  // Back-to-back beats with no stall, a pause until all results are home, then beats with gaps and stalls.
  task automatic test_back_pressure();
    quiet_sender   = 1'b1;
    quiet_receiver = 1'b1;
    test_random_solvable(150);
    quiet_sender   = 1'b0;
    quiet_receiver = 1'b0;
    wait_drained();
    test_random_solvable(100);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_special_cases();
    test_back_pressure();
    test_random_solvable(800);
    test_random_full_range(250);
    wait_drained();
    repeat (PIPE_LAT) @(posedge clk);
    if (pending_q.size() != 0) begin
      n_errors++;
      $display("%0d expected results never arrived", pending_q.size());
    end
    $display("sent %0d beats, checked %0d results", n_sent, n_checked);
    $display("status mix: ok %0d, neg disc %0d, zero disc %0d, zero res %0d",
             n_status[0], n_status[1], n_status[2], n_status[3]);
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: battery_current_from_power.f
rtl/bcp_pkg.sv
rtl/bcp_div_pipe.sv
rtl/battery_current_from_power.sv
tb/tb_battery_current_from_power.sv
